// ===== design/nfed_pkg.sv =====
package nfed_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] CMD_CLICK  = 8'h01;
    localparam logic [7:0] CMD_FILE   = 8'h0A;

    // Number of length nibbles that follow the start byte.
    localparam int unsigned LEN_NIBBLES = 4;

    // Payload byte positions of the click coordinates.
    localparam logic [15:0] CLICK_X_FIRST = 16'd2;
    localparam logic [15:0] CLICK_X_LAST  = 16'd5;
    localparam logic [15:0] CLICK_Y_FIRST = 16'd6;
    localparam logic [15:0] CLICK_Y_LAST  = 16'd9;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_COMMAND = 2'd2,
        PH_BODY    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_CLICK = 2'd0,
        EV_CHAR  = 2'd1,
        EV_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  ch;
        logic        last;
    } t_event;

endpackage

// ===== design/nfed_parse.sv =====
module nfed_parse
    import nfed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  logic [7:0] i_byte,
    output logic       o_evt_vld,
    output t_event     o_evt
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_x, n_x;
    logic [15:0] r_y, n_y;
    logic [3:0]  r_hn, n_hn;

    logic [3:0]  nib;
    logic        pay_done;
    logic [15:0] len_m1;
    logic [15:0] file_end;

    assign nib      = i_byte[3:0];
    assign pay_done = ({1'b0, r_idx} + 17'd1) >= {1'b0, r_len};
    assign len_m1   = r_len - 16'd1;
    // Last index of the paired path nibbles: twice the character count.
    assign file_end = {len_m1[15:1], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_idx   <= '0;
            r_cmd   <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_hn    <= '0;
        end else if (i_vld) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_cmd   <= n_cmd;
            r_x     <= n_x;
            r_y     <= n_y;
            r_hn    <= n_hn;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_x       = r_x;
        n_y       = r_y;
        n_hn      = r_hn;
        o_evt_vld = 1'b0;
        o_evt     = '{kind: EV_CLICK, x: '0, y: '0, ch: '0, last: 1'b0};

        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == START_BYTE) begin
                    n_phase = PH_LENGTH;
                    n_len   = '0;
                    n_idx   = '0;
                end
            end
            PH_LENGTH: begin
                n_len = {r_len[11:0], nib};
                if (r_idx == 16'(LEN_NIBBLES - 1)) begin
                    n_idx   = '0;
                    n_phase = (n_len == '0) ? PH_IDLE : PH_COMMAND;
                end else begin
                    n_idx = r_idx + 16'd1;
                end
            end
            PH_COMMAND: begin
                n_cmd = i_byte;
                n_x   = '0;
                n_y   = '0;
                n_hn  = '0;
                if (i_byte == CMD_FILE && r_len <= 16'd2) begin
                    o_evt_vld = 1'b1;
                    o_evt     = '{kind: EV_EMPTY, x: '0, y: '0, ch: '0, last: 1'b1};
                end
                if (pay_done) begin
                    n_phase = PH_IDLE;
                    n_idx   = '0;
                end else begin
                    n_phase = PH_BODY;
                    n_idx   = r_idx + 16'd1;
                end
            end
            PH_BODY: begin
                if (r_cmd == CMD_CLICK) begin
                    if (r_idx >= CLICK_X_FIRST && r_idx <= CLICK_X_LAST) begin
                        n_x = {r_x[11:0], nib};
                    end else if (r_idx >= CLICK_Y_FIRST && r_idx <= CLICK_Y_LAST) begin
                        n_y = {r_y[11:0], nib};
                        if (r_idx == CLICK_Y_LAST) begin
                            o_evt_vld = 1'b1;
                            o_evt     = '{kind: EV_CLICK, x: r_x, y: n_y, ch: '0,
                                          last: 1'b0};
                        end
                    end
                end else if (r_cmd == CMD_FILE) begin
                    if (r_idx >= 16'd1 && r_idx <= file_end) begin
                        if (r_idx[0]) begin
                            n_hn = nib;
                        end else begin
                            o_evt_vld = 1'b1;
                            o_evt     = '{kind: EV_CHAR, x: '0, y: '0, ch: {r_hn, nib},
                                          last: (r_idx == file_end)};
                        end
                    end
                end
                if (pay_done) begin
                    n_phase = PH_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 16'd1;
                end
            end
        endcase
    end

    a_len_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LENGTH |-> r_idx < 16'(LEN_NIBBLES))
        else $error("length nibble count out of range");

    a_body_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> (r_idx != '0 && r_idx < r_len))
        else $error("payload index outside the frame");

    a_evt_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_vld && i_vld |-> (r_phase == PH_COMMAND || r_phase == PH_BODY))
        else $error("event raised outside a frame payload");

endmodule

// ===== design/nfed_skid.sv =====
module nfed_skid
    import nfed_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_evt,
    output logic   o_ready,
    output logic   o_valid,
    output t_event o_evt,
    input  logic   i_stall
);

    logic   r_main_vld;
    logic   r_skid_vld;
    t_event r_main;
    t_event r_skid;
    logic   pop;

    assign pop     = r_main_vld && !i_stall;
    assign o_ready = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_evt   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_main_vld <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_vld) begin
                r_main_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_evt;
            end
        end else if (i_push) begin
            if (!r_main_vld) begin
                r_main <= i_evt;
            end else begin
                r_skid <= i_evt;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_main_vld)
        else $error("skid entry held without a main entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_push)
        else $error("event pushed into a full output buffer");

endmodule

// ===== design/nibble_frame_event_deframer_top.sv =====
// Deframes a nibble-coded byte stream into click and file-path events. It takes one byte
// per cycle while not stalled and reaches one result per byte: a byte is registered at the
// input, decoded against the frame state in one pass, and its event, if any, lands in a
// two-entry output register. The input stalls only when both output entries are full; a
// click gives one event on its tenth payload byte, a file frame one character per nibble
// pair and an empty-path event on the command byte when the length is one or two.
module nibble_frame_event_deframer_top
    import nfed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [15:0] o_click_x,
    output logic [15:0] o_click_y,
    output logic [7:0]  o_path_char,
    output logic        o_path_last
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       buf_ready;
    logic       go;
    logic       evt_vld;
    t_event     evt;
    t_event     out_evt;

    assign o_stall = r_in_vld && !buf_ready;
    assign go      = r_in_vld && buf_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nfed_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (go),
        .i_byte    (r_in_byte),
        .o_evt_vld (evt_vld),
        .o_evt     (evt)
    );

    nfed_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go && evt_vld),
        .i_evt   (evt),
        .o_ready (buf_ready),
        .o_valid (o_valid),
        .o_evt   (out_evt),
        .i_stall (i_stall)
    );

    assign o_event_kind = out_evt.kind;
    assign o_click_x    = out_evt.x;
    assign o_click_y    = out_evt.y;
    assign o_path_char  = out_evt.ch;
    assign o_path_last  = out_evt.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import nfed_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS  = 20;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_START} t_fill;

    // Predicts the event stream from the accepted bytes and checks the beats that come out.
    class deframer_scoreboard;
        t_phase      phase     = PH_IDLE;
        logic [15:0] frame_len = '0;
        logic [15:0] pay_idx   = '0;
        logic [7:0]  cmd       = '0;
        logic [15:0] x_acc     = '0;
        logic [15:0] y_acc     = '0;
        logic [3:0]  hi_nib    = '0;
        t_event      pending_events[$];
        int unsigned mismatches = 0;
        int unsigned n_click = 0;
        int unsigned n_char  = 0;
        int unsigned n_empty = 0;

        function void push_event(t_kind kind, logic [15:0] x, logic [15:0] y,
                                 logic [7:0] ch, logic last);
            t_event ev;
            ev.kind = kind;
            ev.x    = x;
            ev.y    = y;
            ev.ch   = ch;
            ev.last = last;
            pending_events = {pending_events, ev};
            case (kind)
                EV_CLICK: n_click++;
                EV_CHAR:  n_char++;
                default:  n_empty++;
            endcase
        endfunction

        function void next_payload();
            if (32'(pay_idx) + 32'd1 >= 32'(frame_len)) begin
                phase   = PH_IDLE;
                pay_idx = '0;
            end else begin
                pay_idx = pay_idx + 16'd1;
                phase   = PH_BODY;
            end
        endfunction

        function void note_rx_byte(logic [7:0] rx);
            logic [3:0]  nib;
            logic [15:0] last_idx;
            nib = rx[3:0];
            case (phase)
                PH_LENGTH: begin
                    frame_len = {frame_len[11:0], nib};
                    pay_idx   = pay_idx + 16'd1;
                    if (pay_idx >= LEN_NIBBLES) begin
                        pay_idx = '0;
                        phase   = (frame_len == 16'd0) ? PH_IDLE : PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    cmd    = rx;
                    x_acc  = '0;
                    y_acc  = '0;
                    hi_nib = '0;
                    if (cmd == CMD_FILE && frame_len <= 16'd2) begin
                        push_event(EV_EMPTY, 16'd0, 16'd0, 8'd0, 1'b1);
                    end
                    next_payload();
                end
                PH_BODY: begin
                    if (cmd == CMD_CLICK) begin
                        if (pay_idx >= CLICK_X_FIRST && pay_idx <= CLICK_X_LAST) begin
                            x_acc = {x_acc[11:0], nib};
                        end else if (pay_idx >= CLICK_Y_FIRST && pay_idx <= CLICK_Y_LAST) begin
                            y_acc = {y_acc[11:0], nib};
                            if (pay_idx == CLICK_Y_LAST) begin
                                push_event(EV_CLICK, x_acc, y_acc, 8'd0, 1'b0);
                            end
                        end
                    end else if (cmd == CMD_FILE) begin
                        // Index of the last paired nibble: (len - 1) rounded down to even.
                        last_idx = (frame_len - 16'd1) & 16'hFFFE;
                        if (pay_idx >= 16'd1 && pay_idx <= last_idx) begin
                            if (pay_idx[0]) begin
                                hi_nib = nib;
                            end else begin
                                push_event(EV_CHAR, 16'd0, 16'd0, {hi_nib, nib},
                                           pay_idx == last_idx);
                            end
                        end
                    end
                    next_payload();
                end
                default: begin
                    if (rx == START_BYTE) begin
                        phase     = PH_LENGTH;
                        frame_len = '0;
                        pay_idx   = '0;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                end
            end
        endfunction

        function void check_event(t_event got);
            t_event want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected event, expected none, got kind %0d x %h",
                             $time, got.kind, got.x, " y %h ch %h last %b",
                             got.y, got.ch, got.last);
                end
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", 16'(want.kind), 16'(got.kind));
            compare_field("click_x", want.x, got.x);
            compare_field("click_y", want.y, got.y);
            compare_field("path_char", 16'(want.ch), 16'(got.ch));
            compare_field("path_last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [15:0] o_click_x;
    logic [15:0] o_click_y;
    logic [7:0]  o_path_char;
    logic        o_path_last;

    deframer_scoreboard sb = new;
    logic [7:0]  tx_bytes[$];
    int unsigned bytes_sent = 0;
    logic        steady     = 1'b0;
    logic        hold_req   = 1'b0;

    nibble_frame_event_deframer_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_click_x    (o_click_x),
        .o_click_y    (o_click_y),
        .o_path_char  (o_path_char),
        .o_path_last  (o_path_last)
    );

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] nibble_byte(logic [3:0] nib);
        logic [7:0] r;
        r = 8'($urandom);
        return {r[7:4], nib};
    endfunction

    // Queues one frame: start byte, four length nibbles, then the payload.
    function automatic void add_frame(logic [7:0] cmd, logic [15:0] len, t_fill fill);
        logic [7:0] b;
        tx_bytes = {tx_bytes, START_BYTE};
        for (int i = 3; i >= 0; i--) begin
            tx_bytes = {tx_bytes, nibble_byte(len[4*i +: 4])};
        end
        if (len != 16'd0) begin
            tx_bytes = {tx_bytes, cmd};
        end
        for (int unsigned i = 1; i < len; i++) begin
            case (fill)
                FILL_ZERO:  b = nibble_byte(4'h0);
                FILL_ONES:  b = nibble_byte(4'hF);
                FILL_START: b = START_BYTE;
                default:    b = 8'($urandom);
            endcase
            tx_bytes = {tx_bytes, b};
        end
    endfunction

    // Called and returns at a falling edge; valid stays high between back-to-back beats.
    task automatic send_queued();
        while (tx_bytes.size() > 0) begin
            if (!steady) begin
                while ($urandom_range(0, 99) < 10) begin
                    i_valid   <= 1'b0;
                    i_rx_byte <= 8'($urandom);
                    @(negedge i_clk);
                end
            end
            i_valid   <= 1'b1;
            i_rx_byte <= tx_bytes.pop_front();
            do @(posedge i_clk); while (o_stall);
            @(negedge i_clk);
            bytes_sent++;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(int unsigned n_bytes);
        int unsigned target;
        int unsigned pick;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                add_frame(CMD_CLICK,
                          16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9)
                                                          : $urandom_range(10, 16)),
                          ($urandom_range(0, 9) == 0) ? FILL_START : FILL_RANDOM);
            end else if (pick < 70) begin
                add_frame(CMD_FILE,
                          16'(($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                          : $urandom_range(0, 24)),
                          ($urandom_range(0, 9) == 0) ? FILL_START : FILL_RANDOM);
            end else if (pick < 85) begin
                // Frames with an arbitrary command byte, mostly ones the block skips.
                add_frame(8'($urandom), 16'($urandom_range(0, 20)), FILL_RANDOM);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    tx_bytes = {tx_bytes, 8'($urandom_range(0, 254))};
                end
            end
            send_queued();
        end
    endtask

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall  <= 1'b1;
            end else begin
                i_stall <= !steady && ($urandom_range(0, 99) < 10);
            end
        end
    end

    always @(posedge i_clk) begin : beat_monitor
        t_event got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_rx_byte(i_rx_byte);
            end
            if (o_valid && !i_stall) begin
                got.kind = t_kind'(o_event_kind);
                got.x    = o_click_x;
                got.y    = o_click_y;
                got.ch   = o_path_char;
                got.last = o_path_last;
                sb.check_event(got);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Line noise before any frame is ignored.
        repeat (3) begin
            tx_bytes = {tx_bytes, 8'($urandom_range(0, 254))};
        end
        add_frame(CMD_CLICK, 16'd0, FILL_RANDOM);
        add_frame(CMD_CLICK, 16'd10, FILL_ZERO);
        add_frame(CMD_CLICK, 16'd10, FILL_ONES);
        add_frame(CMD_CLICK, 16'd9, FILL_RANDOM);
        add_frame(CMD_CLICK, 16'd1, FILL_RANDOM);
        add_frame(CMD_CLICK, 16'd14, FILL_RANDOM);
        add_frame(CMD_CLICK, 16'd12, FILL_START);
        add_frame(CMD_FILE, 16'd1, FILL_RANDOM);
        add_frame(CMD_FILE, 16'd2, FILL_RANDOM);
        add_frame(CMD_FILE, 16'd3, FILL_RANDOM);
        add_frame(CMD_FILE, 16'd4, FILL_RANDOM);
        add_frame(CMD_FILE, 16'd9, FILL_ONES);
        add_frame(CMD_FILE, 16'd7, FILL_ZERO);
        add_frame(CMD_FILE, 16'd6, FILL_START);
        // Commands that differ from the known ones only in some bits are skipped.
        add_frame(CMD_FILE | 8'h10, 16'd5, FILL_RANDOM);
        add_frame(CMD_CLICK ^ CMD_CLICK, 16'd11, FILL_RANDOM);
        add_frame(START_BYTE, 16'd3, FILL_RANDOM);
        // A length with two nonzero nibbles and more than 255 payload bytes.
        add_frame(CMD_FILE, 16'h0101, FILL_RANDOM);
        send_queued();
        wait_drained();

        run_random(600);
        wait_drained();

        steady = 1'b1;
        run_random(400);
        steady = 1'b0;

        // The receiver holds off while file frames keep coming, so the input backs up.
        hold_req = 1'b1;
        repeat (6) add_frame(CMD_FILE, 16'd21, FILL_RANDOM);
        send_queued();

        run_random(400);
        wait_drained();

        $display("Run covered %0d bytes in: %0d clicks, %0d path characters, %0d empty paths.",
                 bytes_sent, sb.n_click, sb.n_char, sb.n_empty);
        $display("Directed edge frames, random framed traffic and noise, a no-idle stretch "
                 , "and a long output hold-off.");
        if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
